// ===== sv/ukol_pkg.sv =====
package ukol_pkg;

    localparam logic [2:0] CMD_INS_HEAD = 3'd0;
    localparam logic [2:0] CMD_INS_TAIL = 3'd1;
    localparam logic [2:0] CMD_INS_POS  = 3'd2;
    localparam logic [2:0] CMD_RM_HEAD  = 3'd3;
    localparam logic [2:0] CMD_RM_TAIL  = 3'd4;
    localparam logic [2:0] CMD_RM_KEY   = 3'd5;
    localparam logic [2:0] CMD_RM_POS   = 3'd6;
    localparam logic [2:0] CMD_SEARCH   = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] key;
        logic [7:0]         position;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] removed_key;
        logic [4:0]         count;
    } result_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } cell_op_t;

endpackage

// ===== sv/unique_key_ordered_list.sv =====
// Ordered list of unique signed keys held in a row of cells, one key per cell.
// A command is accepted when start is high and busy is low. In the cycle of
// acceptance every cell compares its key with the command key; in the next
// cycle the list shifts toward or away from the target cell and the result is
// registered. The result is held in result_reg, and done, registered from busy,
// is high for exactly one cycle when it appears; it cannot be held off. busy is
// high for the single cycle of the shift, so no new command is accepted then.
module unique_key_ordered_list #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ukol_pkg::request_t request,
    output ukol_pkg::result_t  result,
    output logic               done
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    ukol_pkg::request_t       req_reg;
    ukol_pkg::result_t        result_reg;
    ukol_pkg::result_t        result_next;

    logic signed [31:0]       key_q   [CAPACITY];
    logic signed [31:0]       sel_key [CAPACITY];
    logic [IDX_W-1:0]         hit_idx [CAPACITY];
    logic [CAPACITY-1:0]      match_vec;

    logic                     accept;
    logic                     found;
    logic [IDX_W-1:0]         where_idx;
    logic signed [31:0]       picked_key;
    logic [IDX_W-1:0]         target;
    ukol_pkg::cell_op_t       op;
    logic                     do_ins;
    logic                     do_rem;
    logic [1:0]               status;
    logic [CW-1:0]            pos_x;
    logic [CW-1:0]            cnt_x;
    logic [IDX_W-1:0]         last_idx;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [31:0] left_key;
            logic signed [31:0] right_key;
            if (g == 0)
            begin : g_first
                assign left_key = key_q[0];
            end
            else
            begin : g_mid_l
                assign left_key = key_q[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_key = key_q[g];
            end
            else
            begin : g_mid_r
                assign right_key = key_q[g+1];
            end
            ukol_cell #(
                .IDX_W (IDX_W),
                .CNT_W (CNT_W),
                .INDEX (g)
            ) u_cell (
                .clk       (clk),
                .cmp_en    (accept),
                .cmp_key   (request.key),
                .load_key  (req_reg.key),
                .count     (count_reg),
                .op        (op),
                .target    (target),
                .left_key  (left_key),
                .right_key (right_key),
                .key       (key_q[g]),
                .match     (match_vec[g]),
                .hit_idx   (hit_idx[g]),
                .sel_key   (sel_key[g])
            );
        end
    endgenerate

    // keys are unique, so at most one cell hits and an or gives its index
    always_comb
    begin
        where_idx  = '0;
        picked_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            where_idx  = where_idx | hit_idx[i];
            picked_key = picked_key | sel_key[i];
        end
    end

    assign found    = |match_vec;
    assign pos_x    = CW'(req_reg.position);
    assign cnt_x    = CW'(count_reg);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        status = ukol_pkg::ST_OK;
        do_ins = 1'b0;
        do_rem = 1'b0;
        target = '0;
        case (req_reg.command)
            ukol_pkg::CMD_INS_HEAD,
            ukol_pkg::CMD_INS_TAIL,
            ukol_pkg::CMD_INS_POS:
            begin
                if (found)
                begin
                    status = ukol_pkg::ST_DUP;
                end
                else if (count_reg >= FULL_CNT)
                begin
                    status = ukol_pkg::ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    if (req_reg.command == ukol_pkg::CMD_INS_HEAD)
                    begin
                        target = '0;
                    end
                    else if (req_reg.command == ukol_pkg::CMD_INS_TAIL || pos_x >= cnt_x)
                    begin
                        target = IDX_W'(count_reg);
                    end
                    else
                    begin
                        target = IDX_W'(req_reg.position);
                    end
                end
            end
            ukol_pkg::CMD_SEARCH:
            begin
                status = found ? ukol_pkg::ST_OK : ukol_pkg::ST_NONE;
            end
            default:
            begin
                if (count_reg == '0)
                begin
                    status = ukol_pkg::ST_NONE;
                end
                else
                begin
                    case (req_reg.command)
                        ukol_pkg::CMD_RM_HEAD:
                        begin
                            do_rem = 1'b1;
                            target = '0;
                        end
                        ukol_pkg::CMD_RM_TAIL:
                        begin
                            do_rem = 1'b1;
                            target = last_idx;
                        end
                        ukol_pkg::CMD_RM_KEY:
                        begin
                            if (found)
                            begin
                                do_rem = 1'b1;
                                target = where_idx;
                            end
                            else
                            begin
                                status = ukol_pkg::ST_NONE;
                            end
                        end
                        default:
                        begin
                            do_rem = 1'b1;
                            if (pos_x >= cnt_x - CW'(1))
                            begin
                                target = last_idx;
                            end
                            else
                            begin
                                target = IDX_W'(req_reg.position);
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    assign op.ins = busy_reg && do_ins;
    assign op.rem = busy_reg && do_rem;

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        result_next.status      = status;
        result_next.found       = found;
        result_next.removed_key = do_rem ? picked_key : '0;
        result_next.count       = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (busy_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== sv/ukol_cell.sv =====
module ukol_cell #(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  logic                cmp_en,
    input  logic signed [31:0]  cmp_key,
    input  logic signed [31:0]  load_key,
    input  logic [CNT_W-1:0]    count,
    input  ukol_pkg::cell_op_t  op,
    input  logic [IDX_W-1:0]    target,
    input  logic signed [31:0]  left_key,
    input  logic signed [31:0]  right_key,
    output logic signed [31:0]  key,
    output logic                match,
    output logic [IDX_W-1:0]    hit_idx,
    output logic signed [31:0]  sel_key
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic signed [31:0] key_reg;
    logic signed [31:0] key_next;
    logic               match_reg;
    logic               match_next;

    always_comb
    begin
        key_next = key_reg;
        if (op.ins)
        begin
            if (MY_IDX == target)
            begin
                key_next = load_key;
            end
            else if (MY_IDX > target)
            begin
                key_next = left_key;
            end
        end
        else if (op.rem)
        begin
            if (MY_IDX >= target)
            begin
                key_next = right_key;
            end
        end
    end

    assign match_next = (MY_CNT < count) && (key_reg == cmp_key);

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (cmp_en)
        begin
            match_reg <= match_next;
        end
    end

    assign key     = key_reg;
    assign match   = match_reg;
    assign hit_idx = match_reg ? MY_IDX : '0;
    assign sel_key = (MY_IDX == target) ? key_reg : '0;

endmodule

// ===== test/unique_key_ordered_list_tb.sv =====
module unique_key_ordered_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ukol_pkg::*;

    localparam int CAP = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    class list_tracker;
        logic signed [31:0] keys[CAP];
        int used;
        result_t pending_results[$];
        int errors;

        function new();
            used = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function int field_mismatch(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $display("%0t: %s expected %h actual %h", $time, name, e, a);
                return 1;
            end
            return 0;
        endfunction

        // works out the list after one command and the result it returns
        function void note_command(request_t r);
            result_t e;
            int where;
            int idx;
            int i;
            where = -1;
            for (i = 0; i < used; i++)
                if (where < 0 && keys[i] == r.key)
                    where = i;
            e = '0;
            e.status = ST_OK;
            e.found = (where >= 0);
            case (r.command)
                CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS:
                begin
                    if (where >= 0)
                        e.status = ST_DUP;
                    else if (used >= CAP)
                        e.status = ST_FULL;
                    else
                    begin
                        if (r.command == CMD_INS_HEAD)
                            idx = 0;
                        else if (r.command == CMD_INS_TAIL)
                            idx = used;
                        else
                            idx = (int'(r.position) >= used) ? used : int'(r.position);
                        for (i = used; i > idx; i--)
                            keys[i] = keys[i - 1];
                        keys[idx] = r.key;
                        used++;
                    end
                end
                CMD_SEARCH:
                    e.status = (where >= 0) ? ST_OK : ST_NONE;
                default:
                begin
                    if (used == 0)
                        e.status = ST_NONE;
                    else
                    begin
                        case (r.command)
                            CMD_RM_HEAD: idx = 0;
                            CMD_RM_TAIL: idx = used - 1;
                            CMD_RM_KEY:  idx = where;
                            default:
                                idx = (int'(r.position) >= used - 1) ? used - 1
                                                                     : int'(r.position);
                        endcase
                        if (idx < 0)
                            e.status = ST_NONE;
                        else
                        begin
                            e.removed_key = keys[idx];
                            for (i = idx; i + 1 < used; i++)
                                keys[i] = keys[i + 1];
                            used--;
                        end
                    end
                end
            endcase
            e.count = used[4:0];
            pending_results.push_back(e);
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %h", $time, got);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            errors += field_mismatch("status", 32'(e.status), 32'(got.status));
            errors += field_mismatch("found", 32'(e.found), 32'(got.found));
            errors += field_mismatch("removed_key", e.removed_key, got.removed_key);
            errors += field_mismatch("count", 32'(e.count), 32'(got.count));
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    result_t  result;
    logic     done;

    list_tracker tracker;
    int cycles;

    logic [2:0] insert_cmds[3] = '{CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS};
    logic [2:0] other_cmds[5] = '{CMD_RM_HEAD, CMD_RM_TAIL, CMD_RM_KEY, CMD_RM_POS, CMD_SEARCH};
    logic signed [31:0] key_pool[12] = '{KEY_MIN, KEY_MAX, 0, -1, 1, 2, 3, 100, -100,
                                         32'sh5555_5555, 32'shaaaa_aaaa, 7};
    int insert_bias[3] = '{85, 15, 50};

    unique_key_ordered_list #(.CAPACITY(CAP)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .result  (result),
        .done    (done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("unique_key_ordered_list_tb: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                tracker.note_command(request);
            if (done)
                tracker.check_result(result);
        end
    end

    function request_t make_req(logic [2:0] c, logic signed [31:0] k, logic [7:0] p);
        request_t r;
        r.command = c;
        r.key = k;
        r.position = p;
        return r;
    endfunction

    function request_t random_req(int ins_pct);
        request_t r;
        if ($urandom_range(99) < ins_pct)
            r.command = insert_cmds[$urandom_range(2)];
        else
            r.command = other_cmds[$urandom_range(4)];
        if ($urandom_range(99) < 60)
            r.key = key_pool[$urandom_range(11)];
        else
            r.key = $urandom;
        if ($urandom_range(99) < 75)
            r.position = 8'($urandom_range(17));
        else
            r.position = 8'($urandom_range(255));
        return r;
    endfunction

    // entered and left at a falling edge
    task send_req(request_t r, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending() != 0);
    endtask

    initial
    begin
        request_t directed[$];
        int n;
        int ins_pct;
        int idle_pct;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        tracker = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed = '{
            make_req(CMD_RM_HEAD, 0, 0),
            make_req(CMD_RM_TAIL, 0, 0),
            make_req(CMD_RM_KEY, 0, 0),
            make_req(CMD_RM_POS, 0, 8'hff),
            make_req(CMD_SEARCH, 0, 0),
            make_req(CMD_INS_TAIL, KEY_MIN, 0),
            make_req(CMD_INS_HEAD, KEY_MAX, 8'hff),
            make_req(CMD_INS_POS, 0, 0),
            make_req(CMD_INS_POS, -1, 8'hff),
            make_req(CMD_INS_POS, 5, 2),
            make_req(CMD_INS_HEAD, 5, 0),
            make_req(CMD_SEARCH, KEY_MAX, 0),
            make_req(CMD_SEARCH, 77, 0),
            make_req(CMD_RM_KEY, 0, 0),
            make_req(CMD_RM_KEY, KEY_MIN, 0),
            make_req(CMD_RM_KEY, -1, 0),
            make_req(CMD_RM_KEY, 99, 0),
            make_req(CMD_INS_TAIL, 7, 0),
            make_req(CMD_RM_POS, 1, 1),
            make_req(CMD_RM_POS, 0, 8'hff),
            make_req(CMD_INS_TAIL, 8, 0),
            make_req(CMD_RM_POS, 0, 0),
            make_req(CMD_RM_HEAD, 0, 0),
            make_req(CMD_INS_HEAD, 3, 0),
            make_req(CMD_RM_TAIL, 0, 0)
        };
        foreach (directed[j])
            send_req(directed[j], 34);

        ins_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                ins_pct = insert_bias[$urandom_range(2)];
            if (n == 700 || n == 1400)
                drain();
            idle_pct = (n < 700) ? 34 : (n < 1400) ? 81 : 0;
            send_req(random_req(ins_pct), idle_pct);
        end

        drain();
        repeat (4) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("unique_key_ordered_list_tb: clean");
        else
            $display("unique_key_ordered_list_tb: errors");
        $finish;
    end

endmodule
